### rtl/scale_space_maxima_refine_core_defines.svh
// assertion macros for the scale-space maxima refine core
`ifndef SCALE_SPACE_MAXIMA_REFINE_CORE_DEFINES_SVH
`define SCALE_SPACE_MAXIMA_REFINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSMR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssmr_pkg.sv
package ssmr_pkg;

    localparam int APB_AW = 5;
    localparam logic [13:0] KEPT_MAX = 14'd16383;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_SIZE_X     = 3'd0;
    localparam logic [2:0] REG_SIZE_Y     = 3'd1;
    localparam logic [2:0] REG_SIZE_Z     = 3'd2;
    localparam logic [2:0] REG_NUM_SCALES = 3'd3;
    localparam logic [2:0] REG_NBH_SIZE   = 3'd4;

    typedef struct packed {
        logic              opcode;
        logic [4:0]        pos_x;
        logic [4:0]        pos_y;
        logic [3:0]        pos_z;
        logic [1:0]        scale_index;
        logic signed [15:0] sample_value;
    } in_word_t;

    typedef struct packed {
        logic              keep;
        logic [4:0]        out_x;
        logic [4:0]        out_y;
        logic [3:0]        out_z;
        logic signed [15:0] out_value;
        logic [13:0]       kept_rank;
    } out_word_t;

    typedef struct packed {
        logic [5:0] size_x;
        logic [5:0] size_y;
        logic [4:0] size_z;
        logic [2:0] num_scales;
        logic [3:0] neighborhood_size;
    } cfg_t;

    typedef struct packed {
        logic query_capture;
        logic load_write;
        logic bounds_load;
        logic scan_start;
        logic scan_step;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
        logic out_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

### rtl/ssmr_regs.sv
module ssmr_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssmr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ssmr_pkg::cfg_t             cfg
);
    import ssmr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_SIZE_X:     cfg_next.size_x = pwdata[5:0];
                REG_SIZE_Y:     cfg_next.size_y = pwdata[5:0];
                REG_SIZE_Z:     cfg_next.size_z = pwdata[4:0];
                REG_NUM_SCALES: cfg_next.num_scales = pwdata[2:0];
                REG_NBH_SIZE:   cfg_next.neighborhood_size = pwdata[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_SIZE_X:     prdata = {26'd0, cfg_reg.size_x};
            REG_SIZE_Y:     prdata = {26'd0, cfg_reg.size_y};
            REG_SIZE_Z:     prdata = {27'd0, cfg_reg.size_z};
            REG_NUM_SCALES: prdata = {29'd0, cfg_reg.num_scales};
            REG_NBH_SIZE:   prdata = {28'd0, cfg_reg.neighborhood_size};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x            <= 6'd32;
            cfg_reg.size_y            <= 6'd32;
            cfg_reg.size_z            <= 5'd16;
            cfg_reg.num_scales        <= 3'd4;
            cfg_reg.neighborhood_size <= 4'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/ssmr_ctrl.sv
module ssmr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_opcode,
    input  ssmr_pkg::dp_status_t status,
    output logic                 req_ready,
    output ssmr_pkg::ctrl_cmd_t  cmd
);
    import ssmr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_opcode == OP_QUERY)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_START;
            ST_START: state_next = status.empty ? ST_DONE : ST_SCAN;
            ST_SCAN:
            begin
                priority if (status.hit)
                begin
                    state_next = ST_DONE;
                end
                else if (status.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready         = 1'b1;
                cmd.query_capture = req_valid && req_opcode == OP_QUERY;
                cmd.load_write    = req_valid && req_opcode == OP_LOAD;
            end
            ST_SETUP: cmd.bounds_load = 1'b1;
            ST_START: cmd.scan_start = 1'b1;
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_DRAIN: cmd = '0;
            ST_DONE:  cmd.result_load = status.out_free;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ssmr_dp.sv
module ssmr_dp #(
    parameter int MAX_X       = 32,
    parameter int MAX_Y       = 32,
    parameter int MAX_Z       = 16,
    parameter int MAX_SCALES  = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssmr_pkg::cfg_t        cfg,
    input  ssmr_pkg::in_word_t    req,
    input  ssmr_pkg::ctrl_cmd_t   cmd,
    output ssmr_pkg::dp_status_t  status,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ssmr_pkg::out_word_t   rsp
);
    import ssmr_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z * MAX_SCALES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic                          wr_en;
    logic signed [SAMPLE_BITS-1:0] wr_data;

    logic [4:0]         qx_reg;
    logic [4:0]         qy_reg;
    logic [3:0]         qz_reg;
    logic signed [15:0] qval_reg;
    logic signed [SAMPLE_BITS-1:0] cand_reg;

    logic [5:0] ilo_reg, ihi_reg, jlo_reg, jhi_reg;
    logic [4:0] klo_reg, khi_reg;
    logic [2:0] shi_reg;
    logic       empty_reg;

    logic [5:0] ilo_next, ihi_next, jlo_next, jhi_next;
    logic [4:0] klo_next, khi_next;
    logic [2:0] shi_next;
    logic       empty_next;

    logic [5:0] sx, sy;
    logic [4:0] sz;
    logic [2:0] ns;
    logic [2:0] delta;
    logic [5:0] x_up, y_up;
    logic [4:0] z_up;

    logic [5:0] ci_reg, cj_reg;
    logic [4:0] ck_reg;
    logic [2:0] cs_reg;
    logic [5:0] ci_next, cj_next;
    logic [4:0] ck_next;
    logic [2:0] cs_next;

    logic       rd_valid_reg;
    logic       hit_reg;
    logic       hit_next;
    logic [13:0] kept_reg;
    logic [13:0] kept_next;

    out_word_t  rsp_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    // store write and read addressing
    assign wr_en = cmd.load_write
                   && int'(req.pos_x) < MAX_X && int'(req.pos_y) < MAX_Y
                   && int'(req.pos_z) < MAX_Z && int'(req.scale_index) < MAX_SCALES;
    assign wr_addr = AW'(int'(req.pos_x) + MAX_X * (int'(req.pos_y) + MAX_Y
                     * (int'(req.pos_z) + MAX_Z * int'(req.scale_index))));
    assign wr_data = SAMPLE_BITS'(req.sample_value);
    assign rd_addr = AW'(int'(ci_reg) + MAX_X * (int'(cj_reg) + MAX_Y
                     * (int'(ck_reg) + MAX_Z * int'(cs_reg))));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // window bounds, clipped to the image
    always_comb
    begin
        sx    = (int'(cfg.size_x) > MAX_X) ? 6'(MAX_X) : cfg.size_x;
        sy    = (int'(cfg.size_y) > MAX_Y) ? 6'(MAX_Y) : cfg.size_y;
        sz    = (int'(cfg.size_z) > MAX_Z) ? 5'(MAX_Z) : cfg.size_z;
        ns    = (int'(cfg.num_scales) > MAX_SCALES) ? 3'(MAX_SCALES) : cfg.num_scales;
        delta = (cfg.neighborhood_size == 4'd0) ? 3'd0
                : 3'((cfg.neighborhood_size - 4'd1) >> 1);
        x_up  = {1'b0, qx_reg} + {3'd0, delta};
        y_up  = {1'b0, qy_reg} + {3'd0, delta};
        z_up  = {1'b0, qz_reg} + {2'd0, delta};
        ilo_next = (qx_reg > {2'd0, delta}) ? {1'b0, qx_reg - {2'd0, delta}} : 6'd0;
        jlo_next = (qy_reg > {2'd0, delta}) ? {1'b0, qy_reg - {2'd0, delta}} : 6'd0;
        klo_next = (qz_reg > {1'd0, delta}) ? {1'b0, qz_reg - {1'd0, delta}} : 5'd0;
        ihi_next = (x_up < sx) ? x_up : sx - 6'd1;
        jhi_next = (y_up < sy) ? y_up : sy - 6'd1;
        khi_next = (z_up < sz) ? z_up : sz - 5'd1;
        shi_next = ns - 3'd1;
        empty_next = (sx == 6'd0) || (sy == 6'd0) || (sz == 5'd0) || (ns == 3'd0)
                     || (ilo_next > ihi_next) || (jlo_next > jhi_next)
                     || (klo_next > khi_next);
    end

    // window walk: x fastest, then y, z, scale
    always_comb
    begin
        ci_next = ci_reg;
        cj_next = cj_reg;
        ck_next = ck_reg;
        cs_next = cs_reg;
        priority if (cmd.scan_start)
        begin
            ci_next = ilo_reg;
            cj_next = jlo_reg;
            ck_next = klo_reg;
            cs_next = 3'd0;
        end
        else if (cmd.scan_step)
        begin
            if (ci_reg != ihi_reg)
            begin
                ci_next = ci_reg + 6'd1;
            end
            else
            begin
                ci_next = ilo_reg;
                if (cj_reg != jhi_reg)
                begin
                    cj_next = cj_reg + 6'd1;
                end
                else
                begin
                    cj_next = jlo_reg;
                    if (ck_reg != khi_reg)
                    begin
                        ck_next = ck_reg + 5'd1;
                    end
                    else
                    begin
                        ck_next = klo_reg;
                        cs_next = cs_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        priority if (cmd.scan_start)
        begin
            hit_next = 1'b0;
        end
        else if (rd_valid_reg && rd_data_reg > cand_reg)
        begin
            hit_next = 1'b1;
        end
    end

    always_comb
    begin
        kept_next = kept_reg;
        priority if (cmd.load_write)
        begin
            kept_next = 14'd0;
        end
        else if (cmd.result_load && !hit_reg && kept_reg != KEPT_MAX)
        begin
            kept_next = kept_reg + 14'd1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.result_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_capture)
        begin
            qx_reg   <= req.pos_x;
            qy_reg   <= req.pos_y;
            qz_reg   <= req.pos_z;
            qval_reg <= req.sample_value;
            cand_reg <= SAMPLE_BITS'(req.sample_value);
        end
        if (cmd.bounds_load)
        begin
            ilo_reg <= ilo_next;
            ihi_reg <= ihi_next;
            jlo_reg <= jlo_next;
            jhi_reg <= jhi_next;
            klo_reg <= klo_next;
            khi_reg <= khi_next;
            shi_reg <= shi_next;
        end
        ci_reg <= ci_next;
        cj_reg <= cj_next;
        ck_reg <= ck_next;
        cs_reg <= cs_next;
        if (cmd.result_load)
        begin
            rsp_reg.keep      <= !hit_reg;
            rsp_reg.out_x     <= qx_reg;
            rsp_reg.out_y     <= qy_reg;
            rsp_reg.out_z     <= qz_reg;
            rsp_reg.out_value <= qval_reg;
            rsp_reg.kept_rank <= kept_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            kept_reg      <= 14'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.bounds_load)
            begin
                empty_reg <= empty_next;
            end
            rd_valid_reg  <= cmd.scan_step;
            hit_reg       <= hit_next;
            kept_reg      <= kept_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign status.empty    = empty_reg;
    assign status.last     = (ci_reg == ihi_reg) && (cj_reg == jhi_reg)
                             && (ck_reg == khi_reg) && (cs_reg == shi_reg);
    assign status.hit      = hit_reg;
    assign status.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/scale_space_maxima_refine_core.sv
// scale-space maxima refine core
// req channel (req_valid/req_ready/req) takes one word per item: opcode 0 writes
// a sample into the multi-scale store and clears the kept counter, opcode 1 tests
// a candidate maximum against its clipped window over all configured scales.
// rsp channel (rsp_valid/rsp_ready/rsp) returns one word per query: keep flag,
// echoed position and value, and the candidate's rank among kept ones.
// a load is taken while the core is idle and returns nothing.
// a query walks its window with one store read per cycle through the single
// read port (108 reads for a 3x3x3 window over 4 scales); the walk stops
// early once a larger sample shows up.
// the result sits in an output register; the core takes new words while it
// waits, and only a second finished query holds until rsp_ready frees it.
// reset clears control state, the kept counter and the configuration to its
// defaults; store contents are undefined until written. the user must write
// configuration over the apb port while the core is idle, which is not enforced.
module scale_space_maxima_refine_core #(
    parameter int MAX_X       = 32,
    parameter int MAX_Y       = 32,
    parameter int MAX_Z       = 16,
    parameter int MAX_SCALES  = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssmr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ssmr_pkg::in_word_t          req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ssmr_pkg::out_word_t         rsp
);
    import ssmr_pkg::*;

    `include "scale_space_maxima_refine_core_defines.svh"

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    ssmr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssmr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .status     (status),
        .req_ready  (req_ready),
        .cmd        (cmd)
    );

    ssmr_dp #(
        .MAX_X       (MAX_X),
        .MAX_Y       (MAX_Y),
        .MAX_Z       (MAX_Z),
        .MAX_SCALES  (MAX_SCALES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `SSMR_ASSERT_IMPLY(a_result_slot_free, cmd.result_load, status.out_free, "result overwrites a pending word")
    `SSMR_ASSERT_NEXT(a_busy_after_query, req_valid && req_ready && req.opcode == OP_QUERY, !req_ready, "word taken right after a query")
    `SSMR_ASSERT_IMPLY(a_no_accept_in_scan, cmd.scan_step, !req_ready && !cmd.load_write, "word taken during window walk")

endmodule
